[design/psi_pkg.sv]
// ----------------------------------------------------------------------------
// psi_pkg: shared types and constants of the pose segment interpolator
// Fixed-point constants, segment descriptor and heading wrap helper.
// ----------------------------------------------------------------------------
package psi_pkg;

  localparam int MAX_STEPS = 63;
  localparam int FAR_BITS  = 27;                      // |dx| or |dy| >= 2^27 -> far
  localparam logic signed [17:0] PI_Q     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
  localparam logic [20:0] STEP_LEN_RESET  = 21'd102;

  // segment descriptor handed from front to back
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] hs;
    logic signed [15:0] dh;
    logic        [5:0]  steps;
  } seg_t;

  // one wrap into [-pi, pi]; inputs stay within about +-2pi
  function automatic logic signed [17:0] wrap_heading(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a > PI_Q) begin
      r = a - TWO_PI_Q;
    end else if (a < -PI_Q) begin
      r = a + TWO_PI_Q;
    end
    return r;
  endfunction

endpackage

[design/psi_front.sv]
// ----------------------------------------------------------------------------
// psi_front: segment intake and step count
// Latches a segment, squares the deltas, then (unless the segment is far)
// sweeps (k*len)^2 against the squared length one k per cycle to find the step count.
// ----------------------------------------------------------------------------
module psi_front import psi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [15:0] start_heading,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [15:0] end_heading,
  input  logic [20:0]        step_length,
  output logic               seg_valid,
  input  logic               seg_ready,
  output seg_t               seg
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_STEP = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]         state;
  logic signed [31:0] sx, sy;
  logic signed [32:0] dx, dy;
  logic signed [15:0] hs, he, dh;
  logic               far;
  logic [55:0]        sqx, sqy, sq;
  logic [56:0]        d2;
  logic [27:0]        r;
  logic [6:0]         k;
  logic [5:0]         kq;
  logic               sqv;
  logic [5:0]         steps;
  logic [27:0]        len;
  logic [32:0]        ax, ay;

  assign len  = (step_length == 21'd0) ? 28'd1 : {7'd0, step_length};
  assign ax   = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay   = dy[32] ? 33'(-dy) : 33'(dy);
  assign full = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      sqv   <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            sx    <= start_x;
            sy    <= start_y;
            dx    <= {end_x[31], end_x} - {start_x[31], start_x};
            dy    <= {end_y[31], end_y} - {start_y[31], start_y};
            hs    <= 16'(wrap_heading(18'(start_heading)));
            he    <= 16'(wrap_heading(18'(end_heading)));
            state <= F_SQ;
          end
        end
        F_SQ: begin
          far   <= (ax[32:FAR_BITS] != '0) || (ay[32:FAR_BITS] != '0);
          sqx   <= ax[27:0] * ax[27:0];
          sqy   <= ay[27:0] * ay[27:0];
          dh    <= 16'(wrap_heading(18'(he) - 18'(hs)));
          state <= F_SUM;
        end
        F_SUM: begin
          if (far) begin
            steps <= 6'(MAX_STEPS);
            state <= F_PUSH;
          end else begin
            d2    <= {1'b0, sqx} + {1'b0, sqy};
            r     <= len;
            k     <= 7'd1;
            sqv   <= 1'b0;
            steps <= 6'd1;
            state <= F_STEP;
          end
        end
        F_STEP: begin
          // square of k*len lands in the cycle after k is issued
          sq  <= r * r;
          kq  <= k[5:0];
          r   <= r + len;
          k   <= k + 7'd1;
          sqv <= 1'b1;
          if (sqv) begin
            if (d2 >= {1'b0, sq}) begin
              steps <= kq;
              if (kq == 6'(MAX_STEPS)) state <= F_PUSH;
            end else begin
              state <= F_PUSH;
            end
          end
        end
        F_PUSH: begin
          sqv <= 1'b0;
          if (seg_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign seg_valid = (state == F_PUSH);
  assign seg = '{sx: sx, sy: sy, dx: dx, dy: dy, hs: hs, dh: dh, steps: steps};

`ifndef SYNTH
  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> (steps != 6'd0)) else $error("zero step count pushed");
  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && !seg_ready) |=> (seg_valid && $stable(steps)))
    else $error("segment dropped before taken");
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (state == F_STEP) |-> full) else $error("intake open while counting");
`endif

endmodule

[design/psi_queue.sv]
// ----------------------------------------------------------------------------
// psi_queue: two-entry segment queue
// Decouples step counting from pose emission.
// ----------------------------------------------------------------------------
module psi_queue import psi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  seg_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output seg_t out_data
);

  seg_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       wr, rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

[design/psi_back.sv]
// ----------------------------------------------------------------------------
// psi_back: pose emission
// Divides the deltas by the step count bit-serially, then walks i = 0..steps
// with quotient/remainder accumulators into the output register.
// ----------------------------------------------------------------------------
module psi_back import psi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  output logic               seg_ready,
  input  seg_t               seg_in,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading,
  output logic [5:0]         step_index,
  output logic               last
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_FIX  = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  typedef struct packed {
    logic [32:0] quo;
    logic [6:0]  rem;
  } div_t;

  typedef struct packed {
    logic signed [33:0] q;
    logic [6:0]         r;
  } qr_t;

  function automatic div_t div_step(input div_t d, input logic [5:0] dv);
    div_t       o;
    logic [6:0] t;
    logic       ge;
    t  = {d.rem[5:0], d.quo[32]};
    ge = (t >= {1'b0, dv});
    o.rem = ge ? (t - {1'b0, dv}) : t;
    o.quo = {d.quo[31:0], ge};
    return o;
  endfunction

  // floor quotient with remainder in [0, steps)
  function automatic qr_t fix_sign(input div_t d, input logic neg, input logic [5:0] dv);
    qr_t o;
    o.q = 34'(d.quo);
    o.r = d.rem;
    if (neg) begin
      if (d.rem != 7'd0) begin
        o.q = -34'(d.quo) - 34'sd1;
        o.r = {1'b0, dv} - d.rem;
      end else begin
        o.q = -34'(d.quo);
      end
    end
    return o;
  endfunction

  function automatic qr_t acc_step(input qr_t a, input qr_t s, input logic [5:0] dv);
    qr_t        o;
    logic [6:0] t;
    t = a.r + s.r;
    if (t >= {1'b0, dv}) begin
      o.q = a.q + s.q + 34'sd1;
      o.r = t - {1'b0, dv};
    end else begin
      o.q = a.q + s.q;
      o.r = t;
    end
    return o;
  endfunction

  logic [1:0]  state;
  seg_t        seg;
  div_t        lx, ly, lh;
  qr_t         qx, qy, qh;
  qr_t         ax, ay, ah;
  logic [5:0]  cnt;
  logic [5:0]  i;
  logic        out_valid;
  logic        emit_ok;
  logic [32:0] mdh;

  assign seg_ready = (state == B_IDLE);
  assign emit_ok   = !out_valid || pop;
  assign empty     = !out_valid;
  assign mdh       = seg_in.dh[15] ? 33'(-34'(seg_in.dh)) : 33'(seg_in.dh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == B_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (seg_valid) begin
            seg    <= seg_in;
            lx.quo <= seg_in.dx[32] ? 33'(-seg_in.dx) : 33'(seg_in.dx);
            ly.quo <= seg_in.dy[32] ? 33'(-seg_in.dy) : 33'(seg_in.dy);
            lh.quo <= mdh;
            lx.rem <= 7'd0;
            ly.rem <= 7'd0;
            lh.rem <= 7'd0;
            cnt    <= 6'd0;
            state  <= B_DIV;
          end
        end
        B_DIV: begin
          lx  <= div_step(lx, seg.steps);
          ly  <= div_step(ly, seg.steps);
          lh  <= div_step(lh, seg.steps);
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) state <= B_FIX;
        end
        B_FIX: begin
          qx    <= fix_sign(lx, seg.dx[32], seg.steps);
          qy    <= fix_sign(ly, seg.dy[32], seg.steps);
          qh    <= fix_sign(lh, seg.dh[15], seg.steps);
          ax    <= '0;
          ay    <= '0;
          ah    <= '0;
          i     <= 6'd0;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (emit_ok) begin
            pos_x      <= seg.sx + ax.q[31:0];
            pos_y      <= seg.sy + ay.q[31:0];
            heading    <= 16'(wrap_heading(18'(seg.hs) + ah.q[17:0]));
            step_index <= i;
            last       <= (i == seg.steps);
            ax         <= acc_step(ax, qx, seg.steps);
            ay         <= acc_step(ay, qy, seg.steps);
            ah         <= acc_step(ah, qh, seg.steps);
            i          <= i + 6'd1;
            if (i == seg.steps) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT) |-> (i <= seg.steps)) else $error("pose index past step count");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT && emit_ok && i == seg.steps) |=> (state == B_IDLE && last))
    else $error("final pose did not close segment");
  a_steps_live: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> (seg.steps != 6'd0)) else $error("zero divisor in use");
`endif

endmodule

[design/pose_segment_interpolator_core.sv]
// ----------------------------------------------------------------------------
// pose_segment_interpolator_core: linear pose interpolation along a segment
// Splits a start/end pose segment into steps+1 evenly spaced poses.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake       Payload
// segment   in         push / full     start_x/y/heading, end_x/y/heading
// pose      out        pop / empty     pos_x, pos_y, heading, step_index, last
// config    in         cfg_we          cfg_data -> step_length (21 bits)
//
// The front finds the step count with a one-k-per-cycle sweep of
// (k*len)^2 against dx^2+dy^2 (a far segment skips the sweep). The back
// runs the 33-bit serial divide, then emits one pose a cycle as long as
// each pose is popped or the output register is empty.
// A two-entry queue sits between front and back, so the next segment is
// counted while poses of the previous one stream out.
// Reset: rst clears all control state and sets step_length to 102.
// Stalls: a held pose (empty low, pop low) pauses the back; once the queue
// fills, the front waits too and full stays high.
// ----------------------------------------------------------------------------
module pose_segment_interpolator_core import psi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [20:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [15:0] start_heading,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [15:0] end_heading,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading,
  output logic [5:0]         step_index,
  output logic               last
);

  logic [20:0] step_length;   // resolution, metres Q10; zero acts as one
  logic        f_valid, f_ready, b_valid, b_ready;
  seg_t        f_seg, b_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_LEN_RESET;
    end else if (cfg_we) begin
      step_length <= cfg_data;
    end
  end

  // intake + step count
  psi_front u_front (
    .clk, .rst, .push, .full,
    .start_x, .start_y, .start_heading, .end_x, .end_y, .end_heading,
    .step_length,
    .seg_valid (f_valid),
    .seg_ready (f_ready),
    .seg       (f_seg)
  );

  // decoupling queue
  psi_queue u_queue (
    .clk, .rst,
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_seg),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_seg)
  );

  // divide + emit
  psi_back u_back (
    .clk, .rst,
    .seg_valid (b_valid),
    .seg_ready (b_ready),
    .seg_in    (b_seg),
    .empty, .pop, .pos_x, .pos_y, .heading, .step_index, .last
  );

endmodule
